>>> rtl/core/pfv_pkg.sv
// Package for the packet frame validator: sizes, register indexes and types.
package pfv_pkg;

  // Longest slot that is checked; bytes beyond it are ignored
  localparam int MAX_SLOT_BYTES = 256;
  // Byte index counts up to and including MAX_SLOT_BYTES
  localparam int IDX_W = $clog2(MAX_SLOT_BYTES + 1);
  // Length of the header in front of the payload
  localparam int HDR_BYTES = 6;
  // Shortest frame: header plus checksum byte
  localparam int MIN_FRAME_BYTES = 7;

  // Byte positions inside a frame
  localparam int POS_MAGIC_HI = 0;
  localparam int POS_MAGIC_LO = 1;
  localparam int POS_TYPE     = 2;
  localparam int POS_LEN_LO   = 4;
  localparam int POS_LEN_HI   = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC_HIGH = 2'd0,
    REG_MAGIC_LOW  = 2'd1
  } cfg_reg_t;

endpackage

>>> rtl/core/packet_frame_validator_xor.sv
// Top level of the packet frame validator: byte-wise frame check with XOR checksum.
//
//  channel | direction | ports                                    | handshake
//  --------+-----------+------------------------------------------+--------------------
//  in      | sink      | in_rx_byte, in_slot_end                  | in_valid / in_stall
//  out     | source    | out_frame_ok, out_message_type,          | out_valid / out_stall
//          |           | out_payload_length                       |
//  cfg     | sink      | cfg_index, cfg_wdata                     | cfg_we
//
// One byte item is taken per cycle unless the input stalls; the slot state updates on
// the same edge. The verdict for a slot appears in the result register in the cycle
// after its slot_end item is accepted. Input stalls only while a verdict waits in the
// result register and the sink stalls. Reset (synchronous, active low) clears the slot
// state, the magic registers and the result valid flag, not the result payload.
module packet_frame_validator_xor
  import pfv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // byte items in
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_slot_end,
  // verdict items out
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_frame_ok,
  output logic [7:0]            out_message_type,
  output logic [15:0]           out_payload_length
);

  // Magic registers
  logic [7:0]  magic_high_r, magic_low_r;

  // Slot state
  idx_t        byte_index_r, byte_index_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic        magic_match_r, magic_match_nxt;
  logic [15:0] declared_length_r, declared_length_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic        verdict_taken_r, verdict_taken_nxt;
  logic        verdict_good_r, verdict_good_nxt;

  // Result register
  logic        out_valid_r;
  logic        frame_ok_r, frame_ok_nxt;
  logic [7:0]  message_type_r, message_type_nxt;
  logic [15:0] payload_length_r, payload_length_nxt;

  logic        in_accept, out_accept;
  logic [16:0] csum_pos;

  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_high_r <= '0;
      magic_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC_HIGH: magic_high_r <= cfg_wdata;
        REG_MAGIC_LOW:  magic_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Position of the checksum byte, formed without wrap
  assign csum_pos = {1'b0, declared_length_r} + 17'(HDR_BYTES);

  // Per-byte slot update and verdict
  always_comb begin
    byte_index_nxt      = byte_index_r;
    running_xor_nxt     = running_xor_r;
    magic_match_nxt     = magic_match_r;
    declared_length_nxt = declared_length_r;
    held_type_nxt       = held_type_r;
    verdict_taken_nxt   = verdict_taken_r;
    verdict_good_nxt    = verdict_good_r;

    if (byte_index_r < IDX_W'(MAX_SLOT_BYTES)) begin
      if (byte_index_r == IDX_W'(POS_MAGIC_HI) && in_rx_byte != magic_high_r)
        magic_match_nxt = 1'b0;
      if (byte_index_r == IDX_W'(POS_MAGIC_LO) && in_rx_byte != magic_low_r)
        magic_match_nxt = 1'b0;
      if (byte_index_r == IDX_W'(POS_TYPE))
        held_type_nxt = in_rx_byte;
      if (byte_index_r == IDX_W'(POS_LEN_LO))
        declared_length_nxt[7:0] = in_rx_byte;
      if (byte_index_r == IDX_W'(POS_LEN_HI))
        declared_length_nxt[15:8] = in_rx_byte;
      // csum_pos is at least HDR_BYTES, so a match implies index >= 6
      if (17'(byte_index_r) == csum_pos) begin
        verdict_taken_nxt = 1'b1;
        verdict_good_nxt  = (in_rx_byte == running_xor_r);
      end
      running_xor_nxt = running_xor_r ^ in_rx_byte;
      byte_index_nxt  = byte_index_r + IDX_W'(1);
    end

    frame_ok_nxt = (byte_index_nxt >= IDX_W'(MIN_FRAME_BYTES)) && magic_match_nxt &&
                   verdict_taken_nxt && verdict_good_nxt;
    message_type_nxt   = (byte_index_nxt >= IDX_W'(POS_TYPE + 1)) ? held_type_nxt : '0;
    payload_length_nxt = (byte_index_nxt >= IDX_W'(HDR_BYTES)) ? declared_length_nxt : '0;
  end

  // Slot state registers; cleared after each slot end
  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_slot_end)) begin
      byte_index_r      <= '0;
      running_xor_r     <= '0;
      magic_match_r     <= 1'b1;
      declared_length_r <= '0;
      held_type_r       <= '0;
      verdict_taken_r   <= 1'b0;
      verdict_good_r    <= 1'b0;
    end else if (in_accept) begin
      byte_index_r      <= byte_index_nxt;
      running_xor_r     <= running_xor_nxt;
      magic_match_r     <= magic_match_nxt;
      declared_length_r <= declared_length_nxt;
      held_type_r       <= held_type_nxt;
      verdict_taken_r   <= verdict_taken_nxt;
      verdict_good_r    <= verdict_good_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_slot_end) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_accept && in_slot_end) begin
      frame_ok_r       <= frame_ok_nxt;
      message_type_r   <= message_type_nxt;
      payload_length_r <= payload_length_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_ok       = frame_ok_r;
  assign out_message_type   = message_type_r;
  assign out_payload_length = payload_length_r;

  // Input is held off only by a waiting, stalled verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled without a pending verdict");

  // A slot end restarts the byte count
  a_slot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_slot_end |=> byte_index_r == '0)
    else $error("byte index not cleared after slot end");

  // Byte index advances by one per byte until it saturates
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_slot_end && byte_index_r < IDX_W'(MAX_SLOT_BYTES)
    |=> byte_index_r == $past(byte_index_r) + IDX_W'(1))
    else $error("byte index did not advance");

  // An accepted frame must fit in the slot
  a_ok_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_ok_r |->
    ({1'b0, payload_length_r} + 17'(MIN_FRAME_BYTES)) <= 17'(MAX_SLOT_BYTES))
    else $error("good verdict for a frame longer than the slot");

endmodule
